/* rtl/core/image_2x_midpoint_upscale_unit_assert.svh */
// Assertion macros used by the checker file of the 2x midpoint upscaler.
`ifndef IMAGE_2X_MIDPOINT_UPSCALE_UNIT_ASSERT_SVH
`define IMAGE_2X_MIDPOINT_UPSCALE_UNIT_ASSERT_SVH

// A property that must hold at every rising clock edge outside reset.
`define IMG2X_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// A signal that must hold its value while a transfer is stalled.
`define IMG2X_ASSERT_HOLD(name, clk, rstn, vld, rdy, sig, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) \
    (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

/* rtl/core/img2x_pkg.sv */
// Package with the types, constants and helpers of the 2x midpoint upscaler.
`default_nettype none

package img2x_pkg;

  localparam int unsigned SrcSide = 8;
  localparam int unsigned PixW    = 11;
  localparam int unsigned CoordW  = 4;
  localparam int unsigned IdxW    = (SrcSide > 1) ? $clog2(SrcSide) : 1;

  typedef logic [PixW-1:0]   pix_t;
  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [CoordW-1:0] coord_t;

  // One classified source pixel with every value it can produce.
  typedef struct packed {
    idx_t row;
    idx_t col;
    pix_t center;
    pix_t vert;
    pix_t horiz;
    pix_t orig;
  } desc_t;

  typedef enum logic [3:0] {
    StepCenter = 4'b0001,
    StepVert   = 4'b0010,
    StepHoriz  = 4'b0100,
    StepOrig   = 4'b1000
  } step_e;

  function automatic pix_t mean2(pix_t a, pix_t b);
    logic [PixW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[PixW:1];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/img2x_if.sv */
// Handshake interfaces for the source pixel channel and the result channel.
`default_nettype none

interface img2x_pix_if;
  logic              valid;
  logic              ready;
  img2x_pkg::pix_t   pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface img2x_res_if;
  logic              valid;
  logic              ready;
  img2x_pkg::coord_t out_row;
  img2x_pkg::coord_t out_col;
  img2x_pkg::pix_t   out_value;
  logic              run_last;

  modport source (output valid, output out_row, output out_col, output out_value,
                  output run_last, input ready);
  modport sink   (input valid, input out_row, input out_col, input out_value,
                  input run_last, output ready);
endinterface

`default_nettype wire

/* rtl/core/img2x_front.sv */
// Front end: accepts source pixels, tracks the raster position and forms all means.
`default_nettype none

module img2x_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  img2x_pix_if.sink             in_if,
  input  wire logic             full_i,
  output logic                  push_o,
  output img2x_pkg::desc_t      desc_o
);

  img2x_pkg::idx_t row_q, row_d;
  img2x_pkg::idx_t col_q, col_d;
  img2x_pkg::pix_t line_q [img2x_pkg::SrcSide];
  img2x_pkg::pix_t above_q;
  img2x_pkg::pix_t left_q;
  img2x_pkg::pix_t upleft_q;
  img2x_pkg::pix_t hbelow;
  logic            accept;
  logic            col_last;
  logic            row_last;

  assign in_if.ready = !full_i;
  assign accept      = in_if.valid && !full_i;
  assign push_o      = accept;

  assign col_last = (col_q == img2x_pkg::IdxW'(img2x_pkg::SrcSide - 1));
  assign row_last = (row_q == img2x_pkg::IdxW'(img2x_pkg::SrcSide - 1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  // The entry for the next position is read into a register ahead of time, so it is ready at the transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_q[col_q] <= in_if.pixel_value;
    end
    above_q <= line_q[col_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      left_q   <= '0;
      upleft_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      if (accept) begin
        left_q   <= in_if.pixel_value;
        upleft_q <= above_q;
      end
    end
  end

  assign hbelow = img2x_pkg::mean2(left_q, in_if.pixel_value);

  always_comb begin
    desc_o.row    = row_q;
    desc_o.col    = col_q;
    desc_o.orig   = in_if.pixel_value;
    desc_o.horiz  = hbelow;
    desc_o.vert   = img2x_pkg::mean2(above_q, in_if.pixel_value);
    desc_o.center = img2x_pkg::mean2(img2x_pkg::mean2(upleft_q, above_q), hbelow);
  end

endmodule

`default_nettype wire

/* rtl/core/img2x_queue.sv */
// Two-entry queue of classified pixels between the front end and the back end.
`default_nettype none

module img2x_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire img2x_pkg::desc_t  desc_i,
  output logic                   full_o,
  output logic                   valid_o,
  input  wire logic              pop_i,
  output img2x_pkg::desc_t       desc_o
);

  img2x_pkg::desc_t mem_q [2];
  logic             wr_q;
  logic             rd_q;
  logic [1:0]       cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign desc_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/img2x_back.sv */
// Back end: walks the results of each queued pixel and drives the output register.
`default_nettype none

module img2x_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire img2x_pkg::desc_t  desc_i,
  output logic                   pop_o,
  img2x_res_if.source            out_if
);

  img2x_pkg::step_e       step_q, step_d;
  img2x_pkg::step_e       sel;
  logic                   ovalid_q;
  img2x_pkg::coord_t      row_q, col_q;
  img2x_pkg::pix_t        value_q;
  logic                   last_q;
  logic                   load;
  logic                   r_pos;
  logic                   c_pos;
  logic [img2x_pkg::IdxW:0] row2, col2;
  img2x_pkg::coord_t      row_even, row_odd, col_even, col_odd;
  img2x_pkg::coord_t      row_sel, col_sel;
  img2x_pkg::pix_t        value_sel;

  assign r_pos = (desc_i.row != '0);
  assign c_pos = (desc_i.col != '0);

  always_comb begin
    case (step_q)
      img2x_pkg::StepCenter: begin
        if (r_pos && c_pos) sel = img2x_pkg::StepCenter;
        else if (r_pos)     sel = img2x_pkg::StepVert;
        else if (c_pos)     sel = img2x_pkg::StepHoriz;
        else                sel = img2x_pkg::StepOrig;
      end
      img2x_pkg::StepVert: begin
        if (r_pos)          sel = img2x_pkg::StepVert;
        else if (c_pos)     sel = img2x_pkg::StepHoriz;
        else                sel = img2x_pkg::StepOrig;
      end
      img2x_pkg::StepHoriz: begin
        sel = c_pos ? img2x_pkg::StepHoriz : img2x_pkg::StepOrig;
      end
      default: begin
        sel = img2x_pkg::StepOrig;
      end
    endcase
  end

  assign row2     = {desc_i.row, 1'b0};
  assign col2     = {desc_i.col, 1'b0};
  assign row_even = img2x_pkg::CoordW'(row2);
  assign col_even = img2x_pkg::CoordW'(col2);
  assign row_odd  = img2x_pkg::CoordW'(row2 - (img2x_pkg::IdxW + 1)'(1));
  assign col_odd  = img2x_pkg::CoordW'(col2 - (img2x_pkg::IdxW + 1)'(1));

  always_comb begin
    case (sel)
      img2x_pkg::StepCenter: begin
        row_sel   = row_odd;
        col_sel   = col_odd;
        value_sel = desc_i.center;
        step_d    = img2x_pkg::StepVert;
      end
      img2x_pkg::StepVert: begin
        row_sel   = row_odd;
        col_sel   = col_even;
        value_sel = desc_i.vert;
        step_d    = img2x_pkg::StepHoriz;
      end
      img2x_pkg::StepHoriz: begin
        row_sel   = row_even;
        col_sel   = col_odd;
        value_sel = desc_i.horiz;
        step_d    = img2x_pkg::StepOrig;
      end
      default: begin
        row_sel   = row_even;
        col_sel   = col_even;
        value_sel = desc_i.orig;
        step_d    = img2x_pkg::StepCenter;
      end
    endcase
  end

  assign load  = valid_i && (!ovalid_q || out_if.ready);
  assign pop_o = load && (sel == img2x_pkg::StepOrig);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= img2x_pkg::StepCenter;
      ovalid_q <= 1'b0;
    end else begin
      if (load) begin
        step_q   <= step_d;
        ovalid_q <= 1'b1;
      end else if (out_if.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      row_q   <= row_sel;
      col_q   <= col_sel;
      value_q <= value_sel;
      last_q  <= (sel == img2x_pkg::StepOrig);
    end
  end

  assign out_if.valid     = ovalid_q;
  assign out_if.out_row   = row_q;
  assign out_if.out_col   = col_q;
  assign out_if.out_value = value_q;
  assign out_if.run_last  = last_q;

endmodule

`default_nettype wire

/* rtl/core/image_2x_midpoint_upscale_unit.sv */
// Top level of the 2x midpoint upscaler.
// Source pixels of a square frame arrive in raster order and each leaves one to four
// tagged pixels of the upscaled frame: one for the first pixel of the frame, two along
// the first row and column, four elsewhere. The back end gives one result per cycle
// through its output register unless the queue is empty or the output stalls, so an
// interior pixel takes four result transfers; a two-entry queue lets the input keep
// taking pixels while results drain. A result passes a queue entry and the output
// register before it is offered. The previous-row store needs no reset clearing.
`default_nettype none

module image_2x_midpoint_upscale_unit (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  img2x_pix_if.sink    in_if,
  img2x_res_if.source  out_if
);

  img2x_pkg::desc_t front_desc;
  img2x_pkg::desc_t queue_desc;
  logic             push;
  logic             full;
  logic             queue_valid;
  logic             pop;

  img2x_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .full_i (full),
    .push_o (push),
    .desc_o (front_desc)
  );

  img2x_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (front_desc),
    .full_o  (full),
    .valid_o (queue_valid),
    .pop_i   (pop),
    .desc_o  (queue_desc)
  );

  img2x_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (queue_valid),
    .desc_i  (queue_desc),
    .pop_o   (pop),
    .out_if  (out_if)
  );

endmodule

`default_nettype wire

/* rtl/core/img2x_checker.sv */
// Port-level checker of the 2x midpoint upscaler and its bind to the top level.
`default_nettype none
`include "image_2x_midpoint_upscale_unit_assert.svh"

module img2x_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire img2x_pkg::coord_t out_row_i,
  input wire img2x_pkg::coord_t out_col_i,
  input wire img2x_pkg::pix_t   out_value_i,
  input wire logic              run_last_i
);

  `IMG2X_ASSERT(a_orig_is_last, clk_i, rst_ni, (out_valid_i && run_last_i) |-> (!out_row_i[0] && !out_col_i[0]), "The last result of a pixel is not on an even position.")
  `IMG2X_ASSERT(a_gap_not_last, clk_i, rst_ni, (out_valid_i && !run_last_i) |-> (out_row_i[0] || out_col_i[0]), "A gap result is marked as last.")
  `IMG2X_ASSERT(a_row_after_gap, clk_i, rst_ni, (out_valid_i && out_ready_i && !run_last_i && out_row_i[0] && out_col_i[0]) |=> (out_valid_i |-> (out_row_i[0] && !out_col_i[0])), "A centre gap is not followed by its vertical gap.")
  `IMG2X_ASSERT_HOLD(a_value_hold, clk_i, rst_ni, out_valid_i, out_ready_i, out_value_i, "The result value changed during a stalled transfer.")

endmodule

bind image_2x_midpoint_upscale_unit img2x_checker u_img2x_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_row_i   (out_if.out_row),
  .out_col_i   (out_if.out_col),
  .out_value_i (out_if.out_value),
  .run_last_i  (out_if.run_last)
);

`default_nettype wire
